// ----- rtl/memory_protection_region_check_macros.svh -----
// Assertion macros for the memory protection region check RTL.
// Included by mprc_verdict, which checks its own logic; no other dependency.
`ifndef MEMORY_PROTECTION_REGION_CHECK_MACROS_SVH
`define MEMORY_PROTECTION_REGION_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MPRC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mprc_pkg.sv -----
// Types and constants of the memory protection region check.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mprc_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_W     = 35;
  localparam int ADDR_W    = 16;
  localparam int IDX_W     = 4;

  localparam logic [REG_W-1:0] REG_RESET = 35'h0_0000_FFFF;
  localparam logic [IDX_W-1:0] NO_MATCH  = 4'd8;

  localparam logic [2:0] DENY_RD = 3'd1;
  localparam logic [2:0] DENY_WR = 3'd2;
  localparam logic [2:0] DENY_EX = 3'd4;

  localparam logic [1:0] CLASS_READ  = 2'd0;
  localparam logic [1:0] CLASS_FETCH = 2'd1;
  localparam logic [1:0] CLASS_WRITE = 2'd2;

  localparam logic [2:0] CODE_NONE         = 3'd0;
  localparam logic [2:0] CODE_READ_DENIED  = 3'd1;
  localparam logic [2:0] CODE_FETCH_DENIED = 3'd2;
  localparam logic [2:0] CODE_WRITE_DENIED = 3'd3;
  localparam logic [2:0] CODE_STOPPED      = 3'd4;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] program_counter;
  } req_t;

  typedef struct packed {
    logic             allowed;
    logic [1:0]       access_class;
    logic [2:0]       violation_code;
    logic [IDX_W-1:0] matched_region;
  } rsp_t;

  // One item in flight along the row of region cells.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [1:0]        access_class;
    logic              hit;
    logic [IDX_W-1:0]  region;
    logic [2:0]        deny;
  } token_t;

  // Deny bit that applies to an access class.
  function automatic logic [2:0] deny_bit(input logic [1:0] cls);
    logic [2:0] bit_sel;
    case (cls)
      CLASS_WRITE: bit_sel = DENY_WR;
      CLASS_FETCH: bit_sel = DENY_EX;
      default:     bit_sel = DENY_RD;
    endcase
    return bit_sel;
  endfunction

  // Violation code for a denied access of a class.
  function automatic logic [2:0] deny_code(input logic [1:0] cls);
    logic [2:0] code;
    case (cls)
      CLASS_WRITE: code = CODE_WRITE_DENIED;
      CLASS_FETCH: code = CODE_FETCH_DENIED;
      default:     code = CODE_READ_DENIED;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/mprc_cell.sv -----
// One region cell: holds one region register and checks the passing item.
// Depends on mprc_pkg.
`timescale 1ns / 1ps

module mprc_cell #(
  parameter int INDEX  = 0,
  parameter bit SEARCH = 1'b1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mprc_pkg::REG_W-1:0]        cfg_data,
  output logic [mprc_pkg::REG_W-1:0]        region,
  input  mprc_pkg::token_t                  tok_in,
  output logic                              ready,
  input  logic                              next_ready,
  output mprc_pkg::token_t                  tok_out
);

  mprc_pkg::token_t tok;
  mprc_pkg::token_t tok_next;
  logic [mprc_pkg::ADDR_W-1:0] lo;
  logic [mprc_pkg::ADDR_W-1:0] hi;
  logic match;

  assign lo    = region[15:0];
  assign hi    = region[31:16];
  assign match = SEARCH && (tok_in.address >= lo) && (tok_in.address <= hi);
  assign ready = !tok.valid || next_ready;

  // Claim the item only if no earlier region did.
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit    = 1'b1;
      tok_next.region = mprc_pkg::IDX_W'(INDEX);
      tok_next.deny   = region[34:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= mprc_pkg::REG_RESET;
    end else if (cfg_we) begin
      region <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (ready) begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

// ----- rtl/mprc_verdict.sv -----
// Final stage: applies deny bits and the sticky stop flag, holds the result.
// Depends on mprc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "memory_protection_region_check_macros.svh"

module mprc_verdict (
  input  logic             clk,
  input  logic             rst,
  input  mprc_pkg::token_t tok_in,
  output logic             ready,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output mprc_pkg::rsp_t   rsp
);

  logic stopped;
  logic take;
  logic denied;
  mprc_pkg::rsp_t rsp_next;

  assign ready  = !rsp_valid || !rsp_stall;
  assign take   = tok_in.valid && ready;
  assign denied = tok_in.hit && ((tok_in.deny & mprc_pkg::deny_bit(tok_in.access_class)) != 3'd0);

  always_comb begin
    rsp_next.access_class = tok_in.access_class;
    if (stopped) begin
      rsp_next.allowed        = 1'b0;
      rsp_next.violation_code = mprc_pkg::CODE_STOPPED;
      rsp_next.matched_region = mprc_pkg::NO_MATCH;
    end else if (denied) begin
      rsp_next.allowed        = 1'b0;
      rsp_next.violation_code = mprc_pkg::deny_code(tok_in.access_class);
      rsp_next.matched_region = tok_in.region;
    end else begin
      rsp_next.allowed        = 1'b1;
      rsp_next.violation_code = mprc_pkg::CODE_NONE;
      rsp_next.matched_region = tok_in.hit ? tok_in.region : mprc_pkg::NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      stopped   <= 1'b0;
    end else begin
      if (ready) begin
        rsp_valid <= tok_in.valid;
      end
      if (take) begin
        rsp <= rsp_next;
        if (denied) begin
          stopped <= 1'b1;
        end
      end
    end
  end

  `MPRC_ASSERT_NXT(a_stop_sticky, clk, rst, stopped, stopped)
  `MPRC_ASSERT_NXT(a_deny_stops, clk, rst, take && denied, stopped)
  `MPRC_ASSERT_IMP(a_allowed_no_code, clk, rst, rsp_valid && rsp.allowed,
                   rsp.violation_code == mprc_pkg::CODE_NONE)
  `MPRC_ASSERT_IMP(a_stopped_no_region, clk, rst,
                   rsp_valid && rsp.violation_code == mprc_pkg::CODE_STOPPED,
                   rsp.matched_region == mprc_pkg::NO_MATCH)

endmodule

// ----- rtl/memory_protection_region_check.sv -----
// Stages: a result passes through the registers of 8 cells, then 1 verdict stage.
// Throughput: one item per cycle unless rsp_stall holds the row; bubbles close up, and an item is taken
//   while a finished result waits as long as the row has room.
// Reset (rst, synchronous): every region reads start 0xFFFF, end 0 (no match),
//   the stop flag clears, and the row empties.
// Depends on mprc_pkg, mprc_cell and mprc_verdict.
`timescale 1ns / 1ps

module memory_protection_region_check #(
  parameter int REGIONS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Access items in
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mprc_pkg::req_t       req,
  // Verdict items out
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output mprc_pkg::rsp_t       rsp,
  // Region configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int N = mprc_pkg::REG_COUNT;

  mprc_pkg::token_t tok [N+1];
  logic [N:0] ready;
  logic [mprc_pkg::REG_W-1:0] regions [N];
  logic wr_en;
  logic fetch;
  logic [mprc_pkg::ADDR_W-1:0] pc_prev;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Read back the addressed region, zero extended.
  assign prdata = {{(64 - mprc_pkg::REG_W){1'b0}}, regions[paddr[5:3]]};

  // Classify the access on the way in: a read one below the PC is a fetch.
  assign pc_prev = req.program_counter - mprc_pkg::ADDR_W'(1);
  assign fetch   = req.address == pc_prev;

  always_comb begin
    tok[0].valid   = req_valid;
    tok[0].address = req.address;
    if (req.is_write) begin
      tok[0].access_class = mprc_pkg::CLASS_WRITE;
    end else if (fetch) begin
      tok[0].access_class = mprc_pkg::CLASS_FETCH;
    end else begin
      tok[0].access_class = mprc_pkg::CLASS_READ;
    end
    tok[0].hit    = 1'b0;
    tok[0].region = mprc_pkg::NO_MATCH;
    tok[0].deny   = 3'd0;
  end

  // Hold the item when the first cell cannot move.
  assign req_stall = !ready[0];

  // Row of region cells, highest priority first; cells past REGIONS keep
  // their register but never claim an item.
  for (genvar i = 0; i < N; i++) begin : g_cell
    mprc_cell #(
      .INDEX  (i),
      .SEARCH (i < REGIONS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg_we     (wr_en && (paddr[5:3] == 3'(i))),
      .cfg_data   (pwdata[mprc_pkg::REG_W-1:0]),
      .region     (regions[i]),
      .tok_in     (tok[i]),
      .ready      (ready[i]),
      .next_ready (ready[i+1]),
      .tok_out    (tok[i+1])
    );
  end

  // Apply deny bits and the stop flag in item order, then hold the result.
  mprc_verdict u_verdict (
    .clk       (clk),
    .rst       (rst),
    .tok_in    (tok[N]),
    .ready     (ready[N]),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
